@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the top-level RTL; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

@@ src/i2cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C bit engine package
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbe_pkg;

   // Request kinds; a tick is carried as CMD_IDLE.
   typedef enum logic [3:0] {
      CMD_IDLE   = 4'd0,
      CMD_START  = 4'd1,
      CMD_STOP   = 4'd2,
      CMD_WRITE  = 4'd3,
      CMD_READ   = 4'd4,
      CMD_CHECK  = 4'd5,
      CMD_ACK    = 4'd6,
      CMD_NACK   = 4'd7,
      CMD_BUSRST = 4'd8
   } cmd_type;

   // Pin sequences the sequencer can be running.
   typedef enum logic [2:0] {
      SUB_START,
      SUB_STOP,
      SUB_WRITE,
      SUB_READ,
      SUB_CHECK,
      SUB_ACKBIT,
      SUB_CLOCKS
   } sub_type;

   localparam int unsigned HALF_W  = 16;
   localparam int unsigned LIMIT_W = 8;

   localparam logic [4:0] PH_END       = 5'd31;
   localparam logic [4:0] POLL_PHASE   = 5'd2;
   localparam logic [3:0] BYTE_BITS    = 4'd8;
   localparam logic [3:0] RESET_CLOCKS = 4'd9;
   localparam logic [1:0] RST_CLOCKS   = 2'd1;
   localparam logic [1:0] RST_STOP     = 2'd3;

   localparam logic [HALF_W-1:0]  HALF_RESET  = 16'd5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd250;

   // Configuration register indexes.
   localparam logic CSR_HALF  = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;

   // One classified request waiting in the queue.
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
      logic       ack_after_read;
      logic       sda_in;
   } item_type;

   // One result.
   typedef struct packed {
      logic       rejected;
      logic       timed_out;
      logic       ack_ok;
      logic [7:0] read_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_release;
      logic       scl;
   } rsp_type;

endpackage

`default_nettype wire

@@ src/i2cbe_front.sv @@
// ----------------------------------------------------------------------------
// I2C bit engine front end
// Accepts requests, classifies the kind and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbe_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [3:0]           in_kind,
   input  wire logic [7:0]           in_data,
   input  wire logic                 in_ack_after_read,
   input  wire logic                 in_sda,
   output logic                      q_valid,
   input  wire logic                 q_ready,
   output i2cbe_pkg::item_type       q_item
);

   i2cbe_pkg::item_type ent_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   i2cbe_pkg::item_type new_item;
   logic                push, pop, is_cmd;

   // Kinds outside the command range behave as ticks.
   assign is_cmd = (in_kind >= 4'(i2cbe_pkg::CMD_START)) &&
                   (in_kind <= 4'(i2cbe_pkg::CMD_BUSRST));

   always_comb begin
      new_item.cmd            = is_cmd ? i2cbe_pkg::cmd_type'(in_kind) : i2cbe_pkg::CMD_IDLE;
      new_item.data           = in_data;
      new_item.ack_after_read = in_ack_after_read;
      new_item.sda_in         = in_sda;
   end

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = ent_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

@@ src/i2cbe_back.sv @@
// ----------------------------------------------------------------------------
// I2C bit engine back end
// Pin sequencer that takes one queued request per cycle into a result register, unless a held result stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbe_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [i2cbe_pkg::HALF_W-1:0]        half_period,
   input  wire logic [i2cbe_pkg::LIMIT_W-1:0]       poll_limit,
   input  wire logic                                q_valid,
   output logic                                     q_ready,
   input  wire i2cbe_pkg::item_type                 q_item,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output i2cbe_pkg::rsp_type                       out_rsp
);

   i2cbe_pkg::cmd_type             cmd_ff, cmd_in;
   logic [4:0]                     phase_ff, phase_in;
   logic [1:0]                     rstage_ff, rstage_in;
   logic [3:0]                     bit_ff, bit_in;
   logic [7:0]                     shift_ff, shift_in;
   logic [i2cbe_pkg::HALF_W-1:0]   delay_ff, delay_in;
   logic [i2cbe_pkg::LIMIT_W-1:0]  poll_ff, poll_in;
   logic                           scl_ff, scl_in;
   logic                           sda_ff, sda_in;
   logic                           ackc_ff, ackc_in;
   logic [7:0]                     rdhold_ff, rdhold_in;
   logic                           ackf_ff, ackf_in;
   logic                           tmo_ff, tmo_in;
   logic                           rsp_valid_ff;
   i2cbe_pkg::rsp_type             rsp_ff, rsp_in;

   logic                           pop, is_cmd, do_exec, done, rej;
   logic                           p_set, p_scl, p_sda, p_wait, ack_level;
   logic [4:0]                     ack_phase;
   i2cbe_pkg::sub_type             sub;

   assign q_ready   = !rsp_valid_ff || out_ready;
   assign pop       = q_valid && q_ready;
   assign is_cmd    = (q_item.cmd != i2cbe_pkg::CMD_IDLE);
   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

   // Next state: one sequencer step for the request at the queue head.
   always_comb begin
      cmd_in    = cmd_ff;
      phase_in  = phase_ff;
      rstage_in = rstage_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      delay_in  = delay_ff;
      poll_in   = poll_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      ackc_in   = ackc_ff;
      rdhold_in = rdhold_ff;
      ackf_in   = ackf_ff;
      tmo_in    = tmo_ff;
      do_exec   = 1'b0;
      done      = 1'b0;
      rej       = 1'b0;
      p_set     = 1'b0;
      p_scl     = 1'b0;
      p_sda     = 1'b0;
      p_wait    = 1'b0;
      sub       = i2cbe_pkg::SUB_START;
      ack_phase = 5'd0;
      ack_level = 1'b0;

      if (cmd_ff == i2cbe_pkg::CMD_IDLE) begin
         if (is_cmd) begin
            cmd_in    = q_item.cmd;
            phase_in  = 5'd0;
            rstage_in = 2'd0;
            bit_in    = 4'd0;
            poll_in   = '0;
            delay_in  = '0;
            shift_in  = (q_item.cmd == i2cbe_pkg::CMD_WRITE) ? q_item.data : 8'd0;
            if (q_item.cmd == i2cbe_pkg::CMD_READ) begin
               ackc_in = q_item.ack_after_read;
            end else if (q_item.cmd == i2cbe_pkg::CMD_ACK) begin
               ackc_in = 1'b1;
            end else if (q_item.cmd == i2cbe_pkg::CMD_NACK) begin
               ackc_in = 1'b0;
            end
            if (q_item.cmd == i2cbe_pkg::CMD_CHECK) begin
               ackf_in = 1'b0;
               tmo_in  = 1'b0;
            end
            do_exec = 1'b1;
         end
      end else begin
         rej = is_cmd;
         if (delay_ff != '0) begin
            delay_in = delay_ff - 1'b1;
         end else if (phase_ff == i2cbe_pkg::PH_END) begin
            if (cmd_ff == i2cbe_pkg::CMD_BUSRST && rstage_ff != i2cbe_pkg::RST_STOP) begin
               rstage_in = rstage_ff + 2'd1;
               phase_in  = 5'd0;
               bit_in    = 4'd0;
               do_exec   = 1'b1;
            end else begin
               cmd_in = i2cbe_pkg::CMD_IDLE;
               done   = 1'b1;
            end
         end else begin
            do_exec = 1'b1;
         end
      end

      if (do_exec) begin
         unique case (cmd_in)
            i2cbe_pkg::CMD_STOP:  sub = i2cbe_pkg::SUB_STOP;
            i2cbe_pkg::CMD_WRITE: sub = i2cbe_pkg::SUB_WRITE;
            i2cbe_pkg::CMD_READ:  sub = i2cbe_pkg::SUB_READ;
            i2cbe_pkg::CMD_CHECK: sub = (rstage_in != 2'd0) ? i2cbe_pkg::SUB_STOP
                                                            : i2cbe_pkg::SUB_CHECK;
            i2cbe_pkg::CMD_ACK, i2cbe_pkg::CMD_NACK: sub = i2cbe_pkg::SUB_ACKBIT;
            i2cbe_pkg::CMD_BUSRST: begin
               if (rstage_in == i2cbe_pkg::RST_CLOCKS) begin
                  sub = i2cbe_pkg::SUB_CLOCKS;
               end else if (rstage_in == i2cbe_pkg::RST_STOP) begin
                  sub = i2cbe_pkg::SUB_STOP;
               end else begin
                  sub = i2cbe_pkg::SUB_START;
               end
            end
            default: sub = i2cbe_pkg::SUB_START;
         endcase

         // The acknowledge bit closes a read and is the whole ack or nack command.
         ack_level = ~ackc_in;
         ack_phase = (sub == i2cbe_pkg::SUB_READ) ? (phase_in - 5'd2) : phase_in;

         unique case (sub)
            i2cbe_pkg::SUB_START: begin
               p_set = 1'b1;
               if (phase_in == 5'd0) begin
                  {p_scl, p_sda, p_wait} = 3'b111;
                  phase_in = 5'd1;
               end else if (phase_in == 5'd1) begin
                  {p_scl, p_sda, p_wait} = 3'b101;
                  phase_in = 5'd2;
               end else begin
                  {p_scl, p_sda, p_wait} = 3'b000;
                  phase_in = i2cbe_pkg::PH_END;
               end
            end
            i2cbe_pkg::SUB_STOP: begin
               p_set = 1'b1;
               if (phase_in == 5'd0) begin
                  {p_scl, p_sda, p_wait} = 3'b001;
                  phase_in = 5'd1;
               end else if (phase_in == 5'd1) begin
                  {p_scl, p_sda, p_wait} = 3'b101;
                  phase_in = 5'd2;
               end else begin
                  {p_scl, p_sda, p_wait} = 3'b111;
                  phase_in = i2cbe_pkg::PH_END;
               end
            end
            i2cbe_pkg::SUB_WRITE: begin
               p_set = 1'b1;
               if (phase_in == 5'd0) begin
                  {p_scl, p_sda, p_wait} = {1'b0, shift_in[7], 1'b1};
                  phase_in = 5'd1;
               end else if (phase_in == 5'd1) begin
                  {p_scl, p_sda, p_wait} = {1'b1, sda_in, 1'b1};
                  shift_in = {shift_in[6:0], 1'b0};
                  bit_in   = bit_in + 4'd1;
                  phase_in = (bit_in < i2cbe_pkg::BYTE_BITS) ? 5'd0 : 5'd2;
               end else begin
                  {p_scl, p_sda, p_wait} = {1'b0, sda_in, 1'b1};
                  phase_in = i2cbe_pkg::PH_END;
               end
            end
            i2cbe_pkg::SUB_CHECK: begin
               if (phase_in == 5'd0) begin
                  p_set = 1'b1;
                  {p_scl, p_sda, p_wait} = {scl_in, 2'b11};
                  phase_in = 5'd1;
               end else if (phase_in == 5'd1) begin
                  p_set = 1'b1;
                  {p_scl, p_sda, p_wait} = 3'b111;
                  phase_in = i2cbe_pkg::POLL_PHASE;
               end else if (!q_item.sda_in) begin
                  // Slave pulled SDA low: acknowledge seen.
                  ackf_in = 1'b1;
                  p_set   = 1'b1;
                  {p_scl, p_sda, p_wait} = 3'b010;
                  phase_in = i2cbe_pkg::PH_END;
               end else if (poll_ff >= poll_limit) begin
                  // Give up and release the bus with a stop sequence.
                  tmo_in    = 1'b1;
                  rstage_in = 2'd1;
                  p_set     = 1'b1;
                  {p_scl, p_sda, p_wait} = 3'b001;
                  phase_in  = 5'd1;
               end else begin
                  poll_in  = poll_ff + 1'b1;
                  delay_in = '0;
               end
            end
            i2cbe_pkg::SUB_CLOCKS: begin
               p_set = 1'b1;
               if (phase_in == 5'd0) begin
                  {p_scl, p_sda, p_wait} = 3'b010;
                  phase_in = 5'd1;
               end else if (phase_in == 5'd1) begin
                  {p_scl, p_sda, p_wait} = 3'b011;
                  phase_in = 5'd2;
               end else if (phase_in == 5'd2) begin
                  {p_scl, p_sda, p_wait} = 3'b111;
                  phase_in = 5'd3;
               end else begin
                  {p_scl, p_sda, p_wait} = 3'b011;
                  bit_in   = bit_in + 4'd1;
                  phase_in = (bit_in < i2cbe_pkg::RESET_CLOCKS) ? 5'd1 : i2cbe_pkg::PH_END;
               end
            end
            default: begin
               // Read bits and the acknowledge bit that follows them.
               p_set = 1'b1;
               if (sub == i2cbe_pkg::SUB_READ && phase_in == 5'd0) begin
                  {p_scl, p_sda, p_wait} = 3'b011;
                  phase_in = 5'd1;
               end else if (sub == i2cbe_pkg::SUB_READ && phase_in == 5'd1) begin
                  {p_scl, p_sda, p_wait} = 3'b111;
                  shift_in = {shift_in[6:0], q_item.sda_in};
                  bit_in   = bit_in + 4'd1;
                  phase_in = (bit_in < i2cbe_pkg::BYTE_BITS) ? 5'd0 : 5'd2;
               end else begin
                  if (sub == i2cbe_pkg::SUB_READ && phase_in == 5'd2) begin
                     rdhold_in = shift_in;
                  end
                  if (ack_phase == 5'd0) begin
                     {p_scl, p_sda, p_wait} = {1'b0, ack_level, 1'b1};
                     phase_in = phase_in + 5'd1;
                  end else if (ack_phase == 5'd1) begin
                     {p_scl, p_sda, p_wait} = {1'b1, ack_level, 1'b1};
                     phase_in = phase_in + 5'd1;
                  end else begin
                     {p_scl, p_sda, p_wait} = {1'b0, ack_level, 1'b0};
                     phase_in = i2cbe_pkg::PH_END;
                  end
               end
            end
         endcase

         if (p_set) begin
            scl_in   = p_scl;
            sda_in   = p_sda;
            delay_in = p_wait ? half_period : '0;
         end
      end
   end

   // Outputs: the result seen after this step.
   always_comb begin
      rsp_in.scl         = scl_in;
      rsp_in.sda_release = sda_in;
      rsp_in.busy_res    = (cmd_in != i2cbe_pkg::CMD_IDLE);
      rsp_in.done_res    = done;
      rsp_in.read_byte   = rdhold_in;
      rsp_in.ack_ok      = ackf_in;
      rsp_in.timed_out   = tmo_in;
      rsp_in.rejected    = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= i2cbe_pkg::CMD_IDLE;
         phase_ff     <= 5'd0;
         rstage_ff    <= 2'd0;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         delay_ff     <= '0;
         poll_ff      <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ackc_ff      <= 1'b0;
         rdhold_ff    <= 8'd0;
         ackf_ff      <= 1'b0;
         tmo_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cmd_ff    <= cmd_in;
            phase_ff  <= phase_in;
            rstage_ff <= rstage_in;
            bit_ff    <= bit_in;
            shift_ff  <= shift_in;
            delay_ff  <= delay_in;
            poll_ff   <= poll_in;
            scl_ff    <= scl_in;
            sda_ff    <= sda_in;
            ackc_ff   <= ackc_in;
            rdhold_ff <= rdhold_in;
            ackf_ff   <= ackf_in;
            tmo_ff    <= tmo_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

@@ src/i2c_master_bit_engine.sv @@
// ----------------------------------------------------------------------------
// I2C master bit engine
// Tick-driven I2C pin sequencer with a request queue and a registered result.
// ----------------------------------------------------------------------------
// Each request is either a tick (kind 0, or an unused kind) or a command:
// start, stop, write byte, read byte, check acknowledge, ack, nack or bus
// reset. A command is taken only when the sequencer is idle; a command that
// arrives while a sequence runs is answered with rejected set and acts as a
// tick. Every request yields exactly one response with the SCL and SDA pin
// levels, busy, done and the latched read byte, ack and timeout flags. The
// engine takes one request per clock and returns one response per clock
// while rsp_tready does not hold a response back; the sequencer performs
// one step per request, which sets that rate. A response passes through
// the two-entry request queue and then the response register.
// The queue lets requests keep flowing while a response waits for rsp_tready.
// The configuration registers (half period in ticks, ack poll limit) must be
// written only while no request is in flight.
`default_nettype none

`include "assert_macros.svh"

module i2c_master_bit_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // data[7:0], ack_after_read[8], sda_in[9], zero
   input  wire logic [3:0]  req_tuser,   // kind[3:0]
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // scl[0], sda_release[1], busy_res[2],
                                         // done_res[3], read_byte[11:4], ack_ok[12],
                                         // timed_out[13], rejected[14], zero
   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);

   logic [i2cbe_pkg::HALF_W-1:0]  half_ff;
   logic [i2cbe_pkg::LIMIT_W-1:0] limit_ff;
   logic                          csr_write;
   logic                          q_valid, q_ready;
   i2cbe_pkg::item_type           q_item;
   i2cbe_pkg::rsp_type            rsp;

   // Configuration registers are always ready to take a write.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff  <= i2cbe_pkg::HALF_RESET;
         limit_ff <= i2cbe_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         if (csr_index == i2cbe_pkg::CSR_HALF) begin
            half_ff <= csr_data;
         end else begin
            limit_ff <= csr_data[i2cbe_pkg::LIMIT_W-1:0];
         end
      end
   end

   // The front end classifies requests and queues them.
   i2cbe_front u_front (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (req_tvalid),
      .in_ready          (req_tready),
      .in_kind           (req_tuser),
      .in_data           (req_tdata[7:0]),
      .in_ack_after_read (req_tdata[8]),
      .in_sda            (req_tdata[9]),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_item            (q_item)
   );

   // The back end runs the pin sequencer and holds the response.
   i2cbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .half_period (half_ff),
      .poll_limit  (limit_ff),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_rsp     (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.rejected, rsp.timed_out, rsp.ack_ok, rsp.read_byte,
                       rsp.done_res, rsp.busy_res, rsp.sda_release, rsp.scl};

   // The back end only stalls the queue while a response is held.
   `ASSERT_PROP(a_back_stall, clock, reset, !q_ready |-> (rsp_tvalid && !rsp_tready))
   // A full queue always has a request to offer.
   `ASSERT_PROP(a_full_has_item, clock, reset, !req_tready |-> q_valid)
   // A finishing response is never busy.
   `ASSERT_NEVER(a_done_busy, clock, reset, rsp_tvalid && rsp.done_res && rsp.busy_res)
   // Ack seen and timeout exclude each other.
   `ASSERT_NEVER(a_ack_tmo, clock, reset, rsp_tvalid && rsp.ack_ok && rsp.timed_out)

endmodule

`default_nettype wire
